/* rtl/core/fmm_pkg.sv */
// shared types, constants and helpers of the matrix multiply block
`timescale 1ns / 1ps

package fmm_pkg;

  // default largest matrix dimension
  localparam int unsigned MaxDimDef = 8;

  // canonical quiet nan
  localparam logic [31:0] QuietNan = 32'h7FC0_0000;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ROW_COUNT   = 2'd0,
    CFG_INNER_COUNT = 2'd1,
    CFG_COL_COUNT   = 2'd2
  } cfg_idx_e;

  // datapath commands from the controller
  typedef struct packed {
    logic       wr_left;
    logic       wr_right;
    logic       clr_acc;
    logic       mul;
    logic       pk1;
    logic       pk2;
    logic       pk3_prod;
    logic       pk3_acc;
    logic       add1;
    logic       add2;
    logic       emit;
    logic       last;
    logic [2:0] row;
    logic [2:0] col;
  } fmm_cmd_t;

  // leading zero count of the 50-bit working word
  function automatic logic [5:0] lzc50(input logic [49:0] w);
    logic [5:0] n;
    n = 6'd50;
    for (int i = 0; i < 50; i++) begin
      if (w[i]) n = 6'(49 - i);
    end
    return n;
  endfunction

endpackage

/* rtl/core/float_matrix_multiply.sv */
// top level of the streaming binary32 matrix multiply
`timescale 1ns / 1ps

// Matrix A (rows x inner) and then matrix B (inner x cols) arrive on the
// element channel, one binary32 word per beat, each row-major. The beat that
// carries the last word of B starts the computation; the block then sends
// every element of A * B on the result channel in row-major order, with
// is_last_o high on the final one. Sums start at +0.0 and add products in
// rising inner order with separate round-to-nearest-even after every multiply
// and every add; subnormals are kept and every nan leaves as 0x7FC00000.
// Loading takes one beat per cycle. Each multiply-add runs through one shared
// multiplier, adder and normalize/round unit in turn: operand read, multiply,
// leading zero count, shift, round, align, add, leading zero count, shift and
// round into the sum. The result sits in an output
// register; while it waits the block keeps computing the next element and
// only holds when that one is ready, and after the last element it takes new
// beats at once. Reset sets all three dimensions to 1 and clears the load
// position; the stores hold no defined contents until loaded. A write to a
// dimension register restarts the load.
module float_matrix_multiply
  import fmm_pkg::*;
#(
  parameter int unsigned MaxDim = MaxDimDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        element_valid_i,
  output logic        element_ready_o,
  input  logic [31:0] element_bits_i,
  output logic        result_valid_o,
  input  logic        result_ready_i,
  output logic [31:0] result_bits_o,
  output logic [2:0]  result_row_o,
  output logic [2:0]  result_col_o,
  output logic        is_last_o
);

  localparam int unsigned Depth = MaxDim * MaxDim;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  fmm_cmd_t         cmd;
  logic [AddrW-1:0] waddr, raddr_a, raddr_b;

  // sequencing and handshakes
  fmm_ctrl #(.MaxDim(MaxDim), .Depth(Depth), .AddrW(AddrW)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .element_valid_i(element_valid_i),
    .element_ready_o(element_ready_o),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .cmd_o          (cmd),
    .waddr_o        (waddr),
    .raddr_a_o      (raddr_a),
    .raddr_b_o      (raddr_b)
  );

  // stores and float arithmetic
  fmm_datapath #(.MaxDim(MaxDim), .Depth(Depth), .AddrW(AddrW)) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .waddr_i       (waddr),
    .raddr_a_i     (raddr_a),
    .raddr_b_i     (raddr_b),
    .element_bits_i(element_bits_i),
    .result_bits_o (result_bits_o),
    .result_row_o  (result_row_o),
    .result_col_o  (result_col_o),
    .is_last_o     (is_last_o)
  );

endmodule

/* rtl/core/fmm_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module fmm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/fmm_datapath.sv */
// matrix stores, float multiply, float add, shared normalize/round unit, result register
`timescale 1ns / 1ps

module fmm_datapath
  import fmm_pkg::*;
#(
  parameter int unsigned MaxDim = MaxDimDef,
  parameter int unsigned Depth  = MaxDim * MaxDim,
  parameter int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fmm_cmd_t         cmd_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  input  logic [31:0]      element_bits_i,
  output logic [31:0]      result_bits_o,
  output logic [2:0]       result_row_o,
  output logic [2:0]       result_col_o,
  output logic             is_last_o
);

  logic [31:0] rd_a, rd_b;

  // operand stores
  fmm_ram #(.Width(32), .Depth(Depth), .AddrW(AddrW)) u_left (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_left),
    .waddr_i(waddr_i),
    .wdata_i(element_bits_i),
    .raddr_i(raddr_a_i),
    .rdata_o(rd_a)
  );

  fmm_ram #(.Width(32), .Depth(Depth), .AddrW(AddrW)) u_right (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_right),
    .waddr_i(waddr_i),
    .wdata_i(element_bits_i),
    .raddr_i(raddr_b_i),
    .rdata_o(rd_b)
  );

  // pack unit registers (working word has its binary point after bit 48)
  logic               pk_s_q;
  logic signed [10:0] pk_e_q;
  logic [49:0]        pk_w_q;
  logic [5:0]         pk_lz_q;
  logic               pk_spec_q;
  logic [31:0]        pk_sbits_q;

  logic [31:0] prod_q, acc_q;

  // adder alignment registers
  logic        ad_s_q, ad_sub_q, ad_spec_q;
  logic [7:0]  ad_e_q;
  logic [49:0] ad_wb_q, ad_ws_q;
  logic [31:0] ad_sbits_q;

  // multiply stage
  logic               mu_spec, mu_s;
  logic [31:0]        mu_sbits;
  logic [47:0]        mu_p;
  logic signed [10:0] mu_e;
  logic [7:0]         ea, eb;
  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

  always_comb begin
    ea     = rd_a[30:23];
    eb     = rd_b[30:23];
    a_nan  = (ea == 8'hFF) && (rd_a[22:0] != 23'd0);
    b_nan  = (eb == 8'hFF) && (rd_b[22:0] != 23'd0);
    a_inf  = (ea == 8'hFF) && (rd_a[22:0] == 23'd0);
    b_inf  = (eb == 8'hFF) && (rd_b[22:0] == 23'd0);
    a_zero = (ea == 8'h00) && (rd_a[22:0] == 23'd0);
    b_zero = (eb == 8'h00) && (rd_b[22:0] == 23'd0);
    mu_s   = rd_a[31] ^ rd_b[31];
    mu_p   = {24'd0, (ea != 8'h00), rd_a[22:0]} * {24'd0, (eb != 8'h00), rd_b[22:0]};
    mu_e   = $signed({3'b000, (ea == 8'h00) ? 8'd1 : ea})
           + $signed({3'b000, (eb == 8'h00) ? 8'd1 : eb}) - 11'sd127;
    mu_spec  = 1'b1;
    mu_sbits = {mu_s, 31'd0};
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      mu_sbits = QuietNan;
    end else if (a_inf || b_inf) begin
      mu_sbits = {mu_s, 8'hFF, 23'd0};
    end else if (a_zero || b_zero) begin
      mu_sbits = {mu_s, 31'd0};
    end else begin
      mu_spec = 1'b0;
    end
  end

  // alignment stage of the adder (x is the running sum, y the product)
  logic        x_nan, y_nan, x_inf, y_inf, x_zero, y_zero, swap, al_spec;
  logic [31:0] al_sbits, big, sml;
  logic [7:0]  eb_eff, es_eff, al_d;
  logic [49:0] al_wb, al_ws0, al_ws, al_mask;

  always_comb begin
    x_nan  = (acc_q[30:23] == 8'hFF) && (acc_q[22:0] != 23'd0);
    y_nan  = (prod_q[30:23] == 8'hFF) && (prod_q[22:0] != 23'd0);
    x_inf  = (acc_q[30:23] == 8'hFF) && (acc_q[22:0] == 23'd0);
    y_inf  = (prod_q[30:23] == 8'hFF) && (prod_q[22:0] == 23'd0);
    x_zero = (acc_q[30:0] == 31'd0);
    y_zero = (prod_q[30:0] == 31'd0);
    al_spec  = 1'b1;
    al_sbits = acc_q;
    if (x_nan || y_nan || (x_inf && y_inf && (acc_q[31] != prod_q[31]))) begin
      al_sbits = QuietNan;
    end else if (x_inf) begin
      al_sbits = acc_q;
    end else if (y_inf) begin
      al_sbits = prod_q;
    end else if (x_zero && y_zero) begin
      al_sbits = {acc_q[31] & prod_q[31], 31'd0};
    end else if (x_zero) begin
      al_sbits = prod_q;
    end else if (y_zero) begin
      al_sbits = acc_q;
    end else begin
      al_spec = 1'b0;
    end
    swap    = prod_q[30:0] > acc_q[30:0];
    big     = swap ? prod_q : acc_q;
    sml     = swap ? acc_q : prod_q;
    eb_eff  = (big[30:23] == 8'h00) ? 8'd1 : big[30:23];
    es_eff  = (sml[30:23] == 8'h00) ? 8'd1 : sml[30:23];
    al_d    = eb_eff - es_eff;
    al_wb   = {1'b0, (big[30:23] != 8'h00), big[22:0], 25'd0};
    al_ws0  = {1'b0, (sml[30:23] != 8'h00), sml[22:0], 25'd0};
    al_mask = '0;
    if (al_d >= 8'd50) begin
      al_ws = {49'd0, |al_ws0};
    end else begin
      al_mask = ~({50{1'b1}} << al_d[5:0]);
      al_ws   = (al_ws0 >> al_d[5:0]) | {49'd0, |(al_ws0 & al_mask)};
    end
  end

  // add stage
  logic [49:0] ad_sum;
  assign ad_sum = ad_sub_q ? (ad_wb_q - ad_ws_q) : (ad_wb_q + ad_ws_q);

  // normalize shift stage of the pack unit
  logic [5:0]         lead, lsh;
  logic signed [10:0] ecand, eo;
  logic signed [8:0]  rsh;
  logic [49:0]        nm_w, nm_mask;

  always_comb begin
    lead  = 6'd49 - pk_lz_q;
    ecand = pk_e_q + $signed({5'b00000, lead}) - 11'sd48;
    if (ecand >= 11'sd1) begin
      rsh = $signed({3'b000, lead}) - 9'sd48;
      eo  = ecand;
    end else begin
      rsh = 9'sd1 - $signed(pk_e_q[8:0]);
      eo  = 11'sd1;
    end
    lsh     = 6'(-rsh);
    nm_mask = '0;
    if (rsh < 9'sd0) begin
      nm_w = pk_w_q << lsh;
    end else if (rsh >= 9'sd50) begin
      nm_w = {49'd0, |pk_w_q};
    end else begin
      nm_mask = ~({50{1'b1}} << rsh[5:0]);
      nm_w    = (pk_w_q >> rsh[5:0]) | {49'd0, |(pk_w_q & nm_mask)};
    end
  end

  // round stage of the pack unit, nearest even
  logic [23:0]        rn_m, rn_mn;
  logic [24:0]        rn_mr;
  logic               rn_up;
  logic signed [10:0] rn_e;
  logic [31:0]        rn_bits;

  always_comb begin
    rn_m  = pk_w_q[48:25];
    rn_up = pk_w_q[24] & ((|pk_w_q[23:0]) | rn_m[0]);
    rn_mr = {1'b0, rn_m} + {24'd0, rn_up};
    if (rn_mr[24]) begin
      rn_mn = rn_mr[24:1];
      rn_e  = pk_e_q + 11'sd1;
    end else begin
      rn_mn = rn_mr[23:0];
      rn_e  = pk_e_q;
    end
    if (pk_spec_q) begin
      rn_bits = pk_sbits_q;
    end else if (rn_e >= 11'sd255) begin
      rn_bits = {pk_s_q, 8'hFF, 23'd0};
    end else begin
      rn_bits = {pk_s_q, rn_mn[23] ? rn_e[7:0] : 8'h00, rn_mn[22:0]};
    end
  end

  // pack unit registers, loaded by the multiply, the adder, the leading zero count or the shift step
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      pk_s_q     <= mu_s;
      pk_e_q     <= mu_e;
      pk_w_q     <= {mu_p, 2'b00};
      pk_spec_q  <= mu_spec;
      pk_sbits_q <= mu_sbits;
    end else if (cmd_i.add2) begin
      pk_s_q     <= ad_s_q;
      pk_e_q     <= $signed({3'b000, ad_e_q});
      pk_w_q     <= ad_sum;
      pk_spec_q  <= ad_spec_q || (ad_sum == 50'd0);
      pk_sbits_q <= ad_spec_q ? ad_sbits_q : 32'd0;
    end else if (cmd_i.pk2) begin
      pk_w_q <= nm_w;
      pk_e_q <= eo;
    end
    if (cmd_i.pk1) pk_lz_q <= lzc50(pk_w_q);
  end

  // adder alignment registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.add1) begin
      ad_s_q     <= big[31];
      ad_sub_q   <= acc_q[31] ^ prod_q[31];
      ad_e_q     <= eb_eff;
      ad_wb_q    <= al_wb;
      ad_ws_q    <= al_ws;
      ad_spec_q  <= al_spec;
      ad_sbits_q <= al_sbits;
    end
  end

  // product and running sum
  always_ff @(posedge clk_i) begin
    if (cmd_i.pk3_prod) prod_q <= rn_bits;
    if (cmd_i.clr_acc) begin
      acc_q <= 32'd0;
    end else if (cmd_i.pk3_acc) begin
      acc_q <= rn_bits;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_bits_o <= acc_q;
      result_row_o  <= cmd_i.row;
      result_col_o  <= cmd_i.col;
      is_last_o     <= cmd_i.last;
    end
  end

  // nan results are always the quiet pattern
  a_acc_qnan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pk3_acc && !cmd_i.clr_acc && (rn_bits[30:23] == 8'hFF) && (rn_bits[22:0] != 23'd0)
    |=> acc_q == QuietNan)
    else $error("running sum holds a non-canonical nan");

  a_prod_qnan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pk3_prod && (rn_bits[30:23] == 8'hFF) && (rn_bits[22:0] != 23'd0)
    |=> prod_q == QuietNan)
    else $error("product holds a non-canonical nan");

endmodule

/* rtl/core/fmm_ctrl.sv */
// controller: configuration, load sequencing, loop counters and result handshake
`timescale 1ns / 1ps

module fmm_ctrl
  import fmm_pkg::*;
#(
  parameter int unsigned MaxDim = MaxDimDef,
  parameter int unsigned Depth  = MaxDim * MaxDim,
  parameter int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [3:0]       cfg_data_i,
  input  logic             element_valid_i,
  output logic             element_ready_o,
  output logic             result_valid_o,
  input  logic             result_ready_i,
  output fmm_cmd_t         cmd_o,
  output logic [AddrW-1:0] waddr_o,
  output logic [AddrW-1:0] raddr_a_o,
  output logic [AddrW-1:0] raddr_b_o
);

  localparam int unsigned PosW = $clog2(2 * Depth);
  localparam int unsigned LenW = PosW + 1;

  typedef enum logic [11:0] {
    ST_LOAD = 12'b0000_0000_0001,
    ST_READ = 12'b0000_0000_0010,
    ST_MUL  = 12'b0000_0000_0100,
    ST_PN1  = 12'b0000_0000_1000,
    ST_PN2  = 12'b0000_0001_0000,
    ST_PRND = 12'b0000_0010_0000,
    ST_ALGN = 12'b0000_0100_0000,
    ST_ADD  = 12'b0000_1000_0000,
    ST_SN1  = 12'b0001_0000_0000,
    ST_SN2  = 12'b0010_0000_0000,
    ST_SRND = 12'b0100_0000_0000,
    ST_OUT  = 12'b1000_0000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [3:0]      row_cnt_q, inner_cnt_q, col_cnt_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [2:0]      row_q, row_d, col_q, col_d, k_q, k_d;
  logic            out_valid_q, out_valid_d;

  logic [3:0]      nr, nk, nc;
  logic [LenW-1:0] a_len, total, pos_eff, pos_nxt;
  logic            k_last, row_last, col_last, accept, emit_go;

  // clamp a dimension register to its working range
  function automatic logic [3:0] eff_dim(input logic [3:0] d);
    logic [3:0] r;
    r = d;
    if (d == 4'd0) r = 4'd1;
    else if (d > 4'(MaxDim)) r = 4'(MaxDim);
    return r;
  endfunction

  assign nr       = eff_dim(row_cnt_q);
  assign nk       = eff_dim(inner_cnt_q);
  assign nc       = eff_dim(col_cnt_q);
  assign a_len    = LenW'(nr) * LenW'(nk);
  assign total    = a_len + LenW'(nk) * LenW'(nc);
  assign pos_eff  = (LenW'(pos_q) >= total) ? '0 : LenW'(pos_q);
  assign pos_nxt  = pos_eff + LenW'(1);
  assign k_last   = ({1'b0, k_q} == nk - 4'd1);
  assign row_last = ({1'b0, row_q} == nr - 4'd1);
  assign col_last = ({1'b0, col_q} == nc - 4'd1);

  assign element_ready_o = (state_q == ST_LOAD);
  assign result_valid_o  = out_valid_q;
  assign accept          = element_ready_o && element_valid_i;
  assign emit_go         = (state_q == ST_OUT) && (!out_valid_q || result_ready_i);

  // store addresses
  logic [7:0] a_idx, b_idx;
  logic [LenW-1:0] w_idx;
  assign w_idx     = (pos_eff < a_len) ? pos_eff : pos_eff - a_len;
  assign a_idx     = 8'(row_q) * 8'(nk) + 8'(k_q);
  assign b_idx     = 8'(k_q) * 8'(nc) + 8'(col_q);
  assign waddr_o   = w_idx[AddrW-1:0];
  assign raddr_a_o = a_idx[AddrW-1:0];
  assign raddr_b_o = b_idx[AddrW-1:0];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q   <= 4'd1;
      inner_cnt_q <= 4'd1;
      col_cnt_q   <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROW_COUNT:   row_cnt_q   <= cfg_data_i;
        CFG_INNER_COUNT: inner_cnt_q <= cfg_data_i;
        CFG_COL_COUNT:   col_cnt_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    row_d       = row_q;
    col_d       = col_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.row   = row_q;
    cmd_o.col   = col_q;
    cmd_o.last  = row_last && col_last;

    if (out_valid_q && result_ready_i) out_valid_d = 1'b0;

    case (state_q)
      ST_LOAD: begin
        if (cfg_we_i && (cfg_index_i inside {CFG_ROW_COUNT, CFG_INNER_COUNT, CFG_COL_COUNT}))
        begin
          pos_d = '0;
        end else if (accept) begin
          cmd_o.wr_left  = (pos_eff < a_len);
          cmd_o.wr_right = !(pos_eff < a_len);
          if (pos_nxt == total) begin
            pos_d         = '0;
            row_d         = '0;
            col_d         = '0;
            k_d           = '0;
            cmd_o.clr_acc = 1'b1;
            state_d       = ST_READ;
          end else begin
            pos_d = pos_nxt[PosW-1:0];
          end
        end
      end
      ST_READ: state_d = ST_MUL;
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_PN1;
      end
      ST_PN1: begin
        cmd_o.pk1 = 1'b1;
        state_d   = ST_PN2;
      end
      ST_PN2: begin
        cmd_o.pk2 = 1'b1;
        state_d   = ST_PRND;
      end
      ST_PRND: begin
        cmd_o.pk3_prod = 1'b1;
        state_d        = ST_ALGN;
      end
      ST_ALGN: begin
        cmd_o.add1 = 1'b1;
        state_d    = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add2 = 1'b1;
        state_d    = ST_SN1;
      end
      ST_SN1: begin
        cmd_o.pk1 = 1'b1;
        state_d   = ST_SN2;
      end
      ST_SN2: begin
        cmd_o.pk2 = 1'b1;
        state_d   = ST_SRND;
      end
      ST_SRND: begin
        cmd_o.pk3_acc = 1'b1;
        if (k_last) begin
          state_d = ST_OUT;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = ST_READ;
        end
      end
      ST_OUT: begin
        if (emit_go) begin
          cmd_o.emit    = 1'b1;
          cmd_o.clr_acc = 1'b1;
          out_valid_d   = 1'b1;
          k_d           = '0;
          if (row_last && col_last) begin
            state_d = ST_LOAD;
          end else begin
            state_d = ST_READ;
            if (col_last) begin
              col_d = '0;
              row_d = row_q + 3'd1;
            end else begin
              col_d = col_q + 3'd1;
            end
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      pos_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      row_q       <= row_d;
      col_q       <= col_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath steps are issued one at a time
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.mul, cmd_o.pk1, cmd_o.pk2, cmd_o.pk3_prod, cmd_o.pk3_acc,
              cmd_o.add1, cmd_o.add2, cmd_o.emit}))
    else $error("more than one datapath step issued");

  // a result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || result_ready_i))
    else $error("result register overwritten");

  // after the final element the block returns to loading
  a_last_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && cmd_o.last |=> element_ready_o && result_valid_o)
    else $error("no return to loading after the last element");

endmodule

/* verif/tb.sv */
// self-checking testbench of the streaming binary32 matrix multiply
`timescale 1ns / 1ps

module tb;
  import fmm_pkg::*;

  localparam int unsigned IdleLimit  = 5000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned SettleCyc  = 20;
  localparam int unsigned RandItems  = 80;
  localparam logic [1:0]  CfgUnused  = 2'd3;

  typedef struct packed {
    logic [31:0] bits;
    logic [2:0]  row;
    logic [2:0]  col;
    logic        last;
  } product_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;
  logic        elem_valid = 1'b0;
  logic        elem_ready;
  logic [31:0] elem_bits = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [31:0] res_bits;
  logic [2:0]  res_row;
  logic [2:0]  res_col;
  logic        res_last;

  // dimension registers, matrix stores and load counter of the predictor
  logic [3:0]  dim_reg [3];
  logic [31:0] a_mem [64];
  logic [31:0] b_mem [64];
  int unsigned load_cnt;
  product_t    product_q [$];

  int unsigned fail_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  bit          hold_req = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  float_matrix_multiply u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .element_valid_i (elem_valid),
    .element_ready_o (elem_ready),
    .element_bits_i  (elem_bits),
    .result_valid_o  (res_valid),
    .result_ready_i  (res_ready),
    .result_bits_o   (res_bits),
    .result_row_o    (res_row),
    .result_col_o    (res_col),
    .is_last_o       (res_last)
  );

  // widen a binary32 pattern to a double exactly
  function automatic real f32_to_real(input logic [31:0] w);
    logic [63:0] d;
    int          e;
    int          p;
    logic [22:0] m;
    e = int'(w[30:23]);
    m = w[22:0];
    if (e == 255) begin
      d = {w[31], 11'h7FF, m, 29'h0};
    end else if (e == 0) begin
      if (m == 0) begin
        d = {w[31], 63'h0};
      end else begin
        p = 22;
        while (!m[p]) p--;
        d = {w[31], 11'(1023 + p - 149), 52'(64'(m) << (52 - p))};
      end
    end else begin
      d = {w[31], 11'(e - 127 + 1023), m, 29'h0};
    end
    return $bitstoreal(d);
  endfunction

  // round a double to binary32, nearest even, subnormals kept, nan made quiet
  function automatic logic [31:0] real_to_f32(input real r);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] q;
    logic        s;
    int          e;
    int          sh;
    d = $realtobits(r);
    s = d[63];
    e = int'(d[62:52]);
    sig = {11'h0, 1'b1, d[51:0]};
    if (e == 2047) return (d[51:0] != 0) ? QuietNan : {s, 8'hFF, 23'h0};
    if (e == 0) return {s, 31'h0};
    e = e - 1023;
    if (e > 127) return {s, 8'hFF, 23'h0};
    if (e >= -126) begin
      sh = 29;
      q = {1'b0, 8'(e + 127), d[51:29]};
    end else begin
      sh = -97 - e;
      if (sh > 60) return {s, 31'h0};
      q = 32'(sig >> sh);
    end
    rem = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    return {s, q[30:0]};
  endfunction

  function automatic int unsigned dim_of(input logic [3:0] v);
    if (v == 0) return 1;
    if (v > MaxDimDef) return MaxDimDef;
    return v;
  endfunction

  // store one loaded word and, when B completes, queue every product element
  task automatic load_element(input logic [31:0] w);
    int unsigned nr;
    int unsigned nk;
    int unsigned nc;
    int unsigned a_len;
    int unsigned total;
    logic [31:0] acc;
    logic [31:0] prod;
    product_t    p;
    nr = dim_of(dim_reg[CFG_ROW_COUNT]);
    nk = dim_of(dim_reg[CFG_INNER_COUNT]);
    nc = dim_of(dim_reg[CFG_COL_COUNT]);
    a_len = nr * nk;
    total = a_len + nk * nc;
    if (load_cnt >= total) load_cnt = 0;
    if (load_cnt < a_len) a_mem[load_cnt] = w;
    else b_mem[load_cnt - a_len] = w;
    load_cnt++;
    if (load_cnt < total) return;
    load_cnt = 0;
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = 32'h0;
        for (int k = 0; k < nk; k++) begin
          prod = real_to_f32(f32_to_real(a_mem[i * nk + k]) * f32_to_real(b_mem[k * nc + j]));
          acc = real_to_f32(f32_to_real(acc) + f32_to_real(prod));
        end
        p.bits = acc;
        p.row = 3'(i);
        p.col = 3'(j);
        p.last = (i == nr - 1 && j == nc - 1);
        product_q.push_back(p);
      end
    end
  endtask

  // one element beat; valid stays up when another beat follows at once
  task automatic send_element(input logic [31:0] w, input bit more);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      elem_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    elem_valid <= 1'b1;
    elem_bits <= w;
    do @(posedge clk_i); while (!elem_ready);
    load_element(w);
    items_sent++;
    if (!more) begin
      elem_valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [3:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk_i);
    if (idx != CfgUnused) begin
      dim_reg[idx] = v;
      load_cnt = 0;
    end
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_dims(input logic [3:0] r, input logic [3:0] k, input logic [3:0] c);
    cfg_write(CFG_ROW_COUNT, r);
    cfg_write(CFG_INNER_COUNT, k);
    cfg_write(CFG_COL_COUNT, c);
  endtask

  // wait for every queued product, then let the block settle
  task automatic drain();
    while (product_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  function automatic logic [31:0] special_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return 32'h7FC0_0001;
      5: return 32'h7F7F_FFFF;
      6: return 32'h0000_0001;
      7: return 32'h007F_FFFF;
      8: return 32'h0080_0000;
      default: return 32'h3F80_0000;
    endcase
  endfunction

  // finite values near one or over a wide range, plus raw patterns, specials and tiny values
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2, 3, 4: return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
      5: return special_word();
      6: return {1'($urandom), 8'($urandom_range(0, 3)), 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(60, 190)), 23'($urandom)};
    endcase
  endfunction

  task automatic send_run(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_element(rand_word(), i != n - 1);
  endtask

  function automatic int unsigned run_len();
    int unsigned nk;
    nk = dim_of(dim_reg[CFG_INNER_COUNT]);
    return nk * (dim_of(dim_reg[CFG_ROW_COUNT]) + dim_of(dim_reg[CFG_COL_COUNT]));
  endfunction

  // dimensions of 1 right after reset
  task automatic test_reset_dims();
    send_element(32'h3FC0_0000, 1'b1);
    send_element(32'hC020_0000, 1'b0);
    drain();
  endtask

  // single products of special values
  task automatic test_special_products();
    logic [31:0] pairs [16];
    pairs = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'h0000_0000,
              32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0000_0001, 32'h3F00_0000,
              32'hFFC1_2345, 32'h3F80_0000, 32'hFF80_0000, 32'hFF80_0000,
              32'hFFFF_FFFF, 32'h0000_0000, 32'h0080_0000, 32'h3F7F_FFFF};
    set_dims(4'd1, 4'd1, 4'd1);
    for (int i = 0; i < 16; i++) send_element(pairs[i], i != 15);
    drain();
  endtask

  // register values of zero and above the largest dimension
  task automatic test_dim_clamp();
    set_dims(4'd0, 4'd0, 4'd15);
    send_run(run_len());
    drain();
    set_dims(4'd9, 4'd1, 4'd0);
    send_run(run_len());
    drain();
  endtask

  // a dimension write restarts the load, the unused index does not
  task automatic test_load_restart();
    set_dims(4'd2, 4'd2, 4'd2);
    send_run(3);
    repeat (SettleCyc) @(posedge clk_i);
    cfg_write(CFG_INNER_COUNT, 4'd2);
    send_run(5);
    cfg_write(CfgUnused, 4'd5);
    send_run(3);
    drain();
  endtask

  // random dimensions and data, with some loads cut short
  task automatic test_random_runs();
    int unsigned target;
    bit          big_done;
    big_done = 1'b0;
    target = items_sent + RandItems;
    while (items_sent < target) begin
      if (!big_done && items_sent > target - 64) begin
        set_dims(4'd4, 4'd8, 4'd4);
        big_done = 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        set_dims(4'($urandom), 4'($urandom_range(1, 3)), 4'($urandom));
      end else begin
        set_dims(4'($urandom_range(1, 3)), 4'($urandom_range(1, 4)), 4'($urandom_range(1, 3)));
      end
      if ($urandom_range(0, 7) == 0) begin
        send_run($urandom_range(1, run_len() - 1 > 0 ? run_len() - 1 : 1));
        repeat (SettleCyc) @(posedge clk_i);
        if (load_cnt == 0) drain();
        cfg_write(CFG_ROW_COUNT, dim_reg[CFG_ROW_COUNT]);
      end
      send_run(run_len());
      drain();
    end
  endtask

  // receiver holds off while two runs are offered, then the sender waits
  task automatic test_backpressure();
    set_dims(4'd3, 4'd2, 4'd3);
    hold_req = 1'b1;
    send_run(run_len());
    send_run(run_len());
    drain();
    send_run(run_len());
    drain();
  endtask

  // no idling on either side
  task automatic test_full_rate();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    set_dims(4'd2, 4'd3, 4'd4);
    send_run(run_len());
    send_run(run_len());
    drain();
    set_dims(4'd4, 4'd1, 4'd2);
    send_run(run_len());
    send_run(run_len());
    drain();
  endtask

  // result ready with random stall bursts and one long hold
  always begin
    @(posedge clk_i);
    if (hold_req) begin
      res_ready <= 1'b0;
      repeat (HoldCycles) @(posedge clk_i);
      hold_req = 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      res_ready <= 1'b0;
      repeat ($urandom_range(1, 12) - 1) @(posedge clk_i);
    end else begin
      res_ready <= 1'b1;
    end
  end

  // compare each result beat with the oldest queued product
  always @(posedge clk_i) begin
    product_t want;
    if (rst_ni && res_valid && res_ready) begin
      if (product_q.size() == 0) begin
        fail_count++;
        if (mismatch_count++ < 10)
          $display("unexpected result beat bits=%h row=%0d col=%0d last=%b",
                   res_bits, res_row, res_col, res_last);
      end else begin
        want = product_q.pop_front();
        if (want.bits !== res_bits || want.row !== res_row || want.col !== res_col ||
            want.last !== res_last) begin
          fail_count++;
          if (mismatch_count++ < 10) begin
            $display("mismatch exp bits=%h row=%0d col=%0d last=%b",
                     want.bits, want.row, want.col, want.last);
            $display("         got bits=%h row=%0d col=%0d last=%b",
                     res_bits, res_row, res_col, res_last);
          end
        end
      end
    end
  end

  // stop when nothing moves on either channel for too long
  always @(posedge clk_i) begin
    if ((elem_valid && elem_ready) || (res_valid && res_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 3; i++) dim_reg[i] = 4'd1;
    load_cnt = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_dims();
    test_special_products();
    test_dim_clamp();
    test_load_restart();
    test_random_runs();
    test_backpressure();
    test_full_rate();
    drain();
    if (fail_count == 0 && product_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/fmm_pkg.sv
rtl/core/fmm_ram.sv
rtl/core/fmm_datapath.sv
rtl/core/fmm_ctrl.sv
rtl/core/float_matrix_multiply.sv
verif/tb.sv
